// ===== src/ausm_pkg.sv =====
package ausm_pkg;

   // Datapath command issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV,
      OP_SPLIT,
      OP_MUL_SQP,
      OP_MUL_SQM,
      OP_MUL_PP1,
      OP_MUL_PM1,
      OP_MUL_PP2,
      OP_MUL_PM2,
      OP_MUL_G0,
      OP_MUL_G1,
      OP_MUL_G2,
      OP_MUL_F0,
      OP_MUL_F1,
      OP_MUL_F2
   } op_type;

   typedef struct packed {
      op_type op;
      logic   emit;
      logic   commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic start_cell;
   } status_type;

endpackage

// ===== src/ausm_ctrl.sv =====
module ausm_ctrl
   import ausm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_DONE} state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      have_prev_ff, have_prev_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Input side is ready whenever idle; an unsent result stalls in ST_DONE
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencer for one cell
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      have_prev_in = have_prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.emit     = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (status.div_done) begin
               state_in = ST_MUL;
               op_in    = OP_SPLIT;
            end
         end
         ST_MUL: begin
            cmd.op = op_ff;
            if (op_ff == OP_MUL_F2 ||
                (op_ff == OP_MUL_G2 && (status.start_cell || !have_prev_ff))) begin
               state_in = ST_DONE;
            end else begin
               op_in = op_type'(op_ff + 4'd1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               have_prev_in = 1'b1;
               if (!status.start_cell && have_prev_ff) begin
                  cmd.emit     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_NONE;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/ausm_dpath.sv =====
module ausm_dpath
   import ausm_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic                        start_of_line,
   input  logic [30:0]                 cell_density,
   input  logic signed [31:0]          cell_velocity,
   input  logic [30:0]                 cell_pressure,
   input  logic [30:0]                 cell_energy,
   input  logic [30:0]                 cell_sound_speed,
   output logic signed [WORD_BITS-1:0] mass_flux,
   output logic signed [WORD_BITS-1:0] momentum_flux,
   output logic signed [WORD_BITS-1:0] energy_flux,
   output logic                        saturated
);

   localparam int W  = WORD_BITS;
   localparam int NB = W + FRAC_BITS;          // dividend bits
   localparam int CW = $clog2(NB + 1);
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = W'(1) <<< FRAC_BITS;
   localparam logic signed [W-1:0] TWO  = W'(2) <<< FRAC_BITS;

   typedef logic signed [W-1:0] word_type;

   // Clamp a 33-bit signed input into the word range
   function automatic word_type clamp_in(input logic signed [32:0] v, output logic c);
      logic signed [W+32:0] e;
      begin
         e = (W+33)'(v);
         c = 1'b0;
         if (e > (W+33)'(WMAX)) begin
            c = 1'b1;
            clamp_in = WMAX;
         end else if (e < (W+33)'(WMIN)) begin
            c = 1'b1;
            clamp_in = WMIN;
         end else begin
            clamp_in = W'(v);
         end
      end
   endfunction

   // Saturating add
   function automatic word_type sat_add(input word_type a, input word_type b,
                                        output logic c);
      logic signed [W:0] s;
      begin
         s = (W+1)'(a) + (W+1)'(b);
         c = 1'b0;
         if (s > (W+1)'(WMAX)) begin
            c = 1'b1;
            sat_add = WMAX;
         end else if (s < (W+1)'(WMIN)) begin
            c = 1'b1;
            sat_add = WMIN;
         end else begin
            sat_add = W'(s);
         end
      end
   endfunction

   // Cell registers
   logic     sol_ff;
   word_type rho_ff, u_ff, p_ff, e_ff, a_ff;
   logic     clip_ff;

   // Divider
   logic [W-1:0]  dmag_ff;
   logic [NB-1:0] num_ff;
   logic [W:0]    rem_ff;
   logic [NB-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          dneg_ff, dbusy_ff;

   // Working values
   word_type m_ff, mp_ff, mm_ff, pp_ff, pm_ff, qm_ff, g0_ff, g1_ff, g2_ff;
   word_type mi_ff, pi_ff;
   logic     up_ff;
   word_type prev_mp_ff, prev_pp_ff, prev_g0_ff, prev_g1_ff, prev_g2_ff;
   word_type f0_ff, f1_ff, f2_ff, f0_in, f1_in, f2_in;
   logic     subs_ff;

   // Shared multiplier operands
   word_type mx, my, mres;
   logic     mclip;

   // Shared Q multiply with magnitude truncation and saturation
   always_comb begin
      logic [W-1:0]   ax, ay;
      logic [2*W-1:0] pr;
      logic [2*W-1:0] sh;
      logic           ng;
      logic [W-1:0]   cap;
      ax = mx[W-1] ? W'(-mx) : W'(mx);
      ay = my[W-1] ? W'(-my) : W'(my);
      ng = mx[W-1] ^ my[W-1];
      pr = (2*W)'(ax) * (2*W)'(ay);
      sh = pr >> FRAC_BITS;
      cap = ng ? W'(WMIN) : W'(WMAX);
      mclip = 1'b0;
      if (sh > (2*W)'(cap)) begin
         mclip = 1'b1;
         sh = (2*W)'(cap);
      end
      mres = ng ? word_type'(-W'(sh)) : word_type'(W'(sh));
   end

   // Operand select per multiply step
   always_comb begin
      mx = '0;
      my = '0;
      unique case (cmd.op)
         OP_MUL_SQP: begin mx = m_ff + ONE;  my = m_ff + ONE; end
         OP_MUL_SQM: begin mx = m_ff - ONE;  my = m_ff - ONE; end
         OP_MUL_PP1: begin mx = mp_ff;       my = TWO - m_ff; end
         OP_MUL_PM1: begin mx = qm_ff;       my = TWO + m_ff; end
         OP_MUL_PP2: begin mx = pp_ff;       my = p_ff; end
         OP_MUL_PM2: begin mx = pm_ff;       my = p_ff; end
         OP_MUL_G0:  begin mx = rho_ff;      my = a_ff; end
         OP_MUL_G1:  begin mx = g0_ff;       my = u_ff; end
         OP_MUL_G2:  begin mx = a_ff;        my = pi_ff; end
         OP_MUL_F0:  begin mx = mi_ff;       my = up_ff ? prev_g0_ff : g0_ff; end
         OP_MUL_F1:  begin mx = mi_ff;       my = up_ff ? prev_g1_ff : g1_ff; end
         OP_MUL_F2:  begin mx = mi_ff;       my = up_ff ? prev_g2_ff : g2_ff; end
         default: ;
      endcase
   end

   assign status.div_done   = dbusy_ff && (cnt_ff == '0);
   assign status.start_cell = sol_ff;

   // Main datapath register updates
   always_ff @(posedge clock) begin
      logic     c0, c1, c2, c3, c4;
      word_type t0, t1;
      logic [W:0] trial;
      if (reset) begin
         dbusy_ff   <= 1'b0;
         cnt_ff     <= '0;
         prev_mp_ff <= '0;
         prev_pp_ff <= '0;
         prev_g0_ff <= '0;
         prev_g1_ff <= '0;
         prev_g2_ff <= '0;
         saturated  <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               sol_ff <= start_of_line;
               rho_ff <= clamp_in({2'b0, cell_density}, c0);
               u_ff   <= clamp_in({cell_velocity[31], cell_velocity}, c1);
               p_ff   <= clamp_in({2'b0, cell_pressure}, c2);
               e_ff   <= clamp_in({2'b0, cell_energy}, c3);
               a_ff   <= clamp_in({2'b0, cell_sound_speed}, c4);
               clip_ff <= c0 | c1 | c2 | c3 | c4;
            end
            OP_DIV: begin
               if (!dbusy_ff) begin
                  // Set up one quotient bit per cycle
                  dbusy_ff <= 1'b1;
                  cnt_ff   <= CW'(NB);
                  dneg_ff  <= u_ff[W-1];
                  dmag_ff  <= W'(a_ff);
                  num_ff   <= NB'(u_ff[W-1] ? W'(-u_ff) : W'(u_ff)) << FRAC_BITS;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
               end else if (cnt_ff != '0) begin
                  trial = {rem_ff[W-1:0], num_ff[NB-1]};
                  num_ff <= num_ff << 1;
                  cnt_ff <= cnt_ff - 1'b1;
                  if (trial >= (W+1)'(dmag_ff)) begin
                     rem_ff <= trial - (W+1)'(dmag_ff);
                     quo_ff <= {quo_ff[NB-2:0], 1'b1};
                  end else begin
                     rem_ff <= trial;
                     quo_ff <= {quo_ff[NB-2:0], 1'b0};
                  end
               end else begin
                  dbusy_ff <= 1'b0;
                  if (a_ff == '0) begin
                     m_ff <= (u_ff == '0) ? '0 : (dneg_ff ? WMIN : WMAX);
                     if (u_ff != '0) clip_ff <= 1'b1;
                  end else if (quo_ff > {{(NB-W){1'b0}}, (dneg_ff ? WMIN : WMAX)}) begin
                     clip_ff <= 1'b1;
                     m_ff <= dneg_ff ? WMIN : WMAX;
                  end else begin
                     m_ff <= dneg_ff ? word_type'(-W'(quo_ff)) : word_type'(W'(quo_ff));
                  end
               end
            end
            OP_SPLIT: begin
               // Region select and sum E+p
               subs_ff <= (m_ff >= -ONE) && (m_ff <= ONE);
               if (m_ff > ONE) begin
                  mp_ff <= m_ff; mm_ff <= '0; pp_ff <= p_ff; pm_ff <= '0;
               end else if (m_ff < -ONE) begin
                  mp_ff <= '0; mm_ff <= m_ff; pp_ff <= '0; pm_ff <= p_ff;
               end
               pi_ff <= sat_add(e_ff, p_ff, c0);
               if (c0) clip_ff <= 1'b1;
            end
            OP_MUL_SQP: if (subs_ff) begin
               mp_ff <= mres >>> 2;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_SQM: if (subs_ff) begin
               qm_ff <= mres >>> 2;
               mm_ff <= -(mres >>> 2);
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_PP1: if (subs_ff) begin
               pp_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_PM1: if (subs_ff) begin
               pm_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_PP2: if (subs_ff) begin
               pp_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_PM2: begin
               if (subs_ff) begin
                  pm_ff <= mres;
                  if (mclip) clip_ff <= 1'b1;
                  t0 = mres;
               end else begin
                  t0 = pm_ff;
               end
               // Interface Mach and pressure
               t1 = sat_add(prev_mp_ff, mm_ff, c0);
               mi_ff <= t1;
               up_ff <= !t1[W-1];
               pi_ff <= pi_ff;
               f1_ff <= sat_add(prev_pp_ff, t0, c1);
               if (sol_ff == 1'b0 && (c0 || c1)) clip_ff <= 1'b1;
            end
            OP_MUL_G0: begin
               g0_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_G1: begin
               g1_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_G2: begin
               g2_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_F0: begin
               f0_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            OP_MUL_F1: begin
               f2_ff <= sat_add(mres, f1_ff, c0);
               if (mclip || c0) clip_ff <= 1'b1;
            end
            OP_MUL_F2: begin
               f1_ff <= f2_ff;
               f2_ff <= mres;
               if (mclip) clip_ff <= 1'b1;
            end
            default: ;
         endcase
         // Latch result and this cell's state
         if (cmd.emit) begin
            saturated <= clip_ff;
         end
         if (cmd.commit) begin
            prev_mp_ff <= mp_ff;
            prev_pp_ff <= pp_ff;
            prev_g0_ff <= g0_ff;
            prev_g1_ff <= g1_ff;
            prev_g2_ff <= g2_ff;
         end
      end
   end

   assign f0_in = f0_ff;
   assign f1_in = f1_ff;
   assign f2_in = f2_ff;

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         mass_flux     <= f0_in;
         momentum_flux <= f1_in;
         energy_flux   <= f2_in;
      end
   end

endmodule

// ===== src/ausm_interface_flux.sv =====
// AUSM interface flux: one 1D Euler cell per item, signed fixed point with
// FRAC_BITS fraction bits. After each cell that follows another in the same
// line, one item is given with the mass, momentum and energy flux at the
// face between them, saturated, with a flag for any clip on the way. A new
// item is taken only once the last cell is through. The Mach number comes
// from a restoring divider at one quotient bit per cycle, with one set-up
// and one finishing step. Then come the split region select and twelve
// steps on one shared multiplier. The done state writes the result, and the
// idle state takes the next item. The first cell of a line skips the three
// flux multiplies. A result that has not yet been taken holds the next cell
// back only in that cell's done state.
module ausm_interface_flux
   import ausm_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_start_of_line,
   input  logic [30:0]                 req_cell_density,
   input  logic signed [31:0]          req_cell_velocity,
   input  logic [30:0]                 req_cell_pressure,
   input  logic [30:0]                 req_cell_energy,
   input  logic [30:0]                 req_cell_sound_speed,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_mass_flux,
   output logic signed [WORD_BITS-1:0] rsp_momentum_flux,
   output logic signed [WORD_BITS-1:0] rsp_energy_flux,
   output logic                        rsp_saturated
);

   cmd_type    cmd;
   status_type status;

   ausm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ausm_dpath #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .start_of_line    (req_start_of_line),
      .cell_density     (req_cell_density),
      .cell_velocity    (req_cell_velocity),
      .cell_pressure    (req_cell_pressure),
      .cell_energy      (req_cell_energy),
      .cell_sound_speed (req_cell_sound_speed),
      .mass_flux        (rsp_mass_flux),
      .momentum_flux    (rsp_momentum_flux),
      .energy_flux      (rsp_energy_flux),
      .saturated        (rsp_saturated)
   );

endmodule

// ===== tb/ausm_flux_checker.sv =====
// Watches both channels, predicts the interface flux of every accepted cell that
// follows another in its line and compares each result item with the oldest prediction.
module ausm_flux_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_start_of_line,
   input  logic [30:0]        req_cell_density,
   input  logic signed [31:0] req_cell_velocity,
   input  logic [30:0]        req_cell_pressure,
   input  logic [30:0]        req_cell_energy,
   input  logic [30:0]        req_cell_sound_speed,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_mass_flux,
   input  logic signed [31:0] rsp_momentum_flux,
   input  logic signed [31:0] rsp_energy_flux,
   input  logic               rsp_saturated,
   output int                 fail_count,
   output int                 pending
);

   localparam longint WMAX  = 64'sd2147483647;
   localparam longint WMIN  = -64'sd2147483648;
   localparam longint ONE_Q = 64'sd65536;

   typedef struct {
      logic signed [31:0] mass;
      logic signed [31:0] momentum;
      logic signed [31:0] energy;
      logic               sat;
   } flux_type;

   flux_type flux_q[$];
   logic     clip;
   logic     have_prev;
   longint   prev_mp, prev_pp, prev_g0, prev_g1, prev_g2;

   function automatic longint clampw(longint v);
      if (v > WMAX) begin
         clip = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         clip = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint sat_add(longint a, longint b);
      return clampw(a + b);
   endfunction

   // magnitude product, truncated, clipped to the signed range
   function automatic longint mulq(longint x, longint y);
      logic         neg;
      logic [63:0]  mx, my, cap;
      logic [127:0] s;
      neg = (x < 0) != (y < 0);
      mx  = (x < 0) ? -x : x;
      my  = (y < 0) ? -y : y;
      s   = ({64'd0, mx} * {64'd0, my}) >> 16;
      cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (s > {64'd0, cap}) begin
         clip = 1'b1;
         s = {64'd0, cap};
      end
      return neg ? -longint'(s[63:0]) : longint'(s[63:0]);
   endfunction

   function automatic longint divq(longint x, longint d);
      logic         neg;
      logic [63:0]  mx, cap;
      logic [127:0] s;
      neg = x < 0;
      if (d <= 0) begin
         if (x == 0) return 0;
         clip = 1'b1;
         return neg ? WMIN : WMAX;
      end
      mx  = neg ? -x : x;
      s   = ({64'd0, mx} << 16) / {64'd0, d};
      cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (s > {64'd0, cap}) begin
         clip = 1'b1;
         s = {64'd0, cap};
      end
      return neg ? -longint'(s[63:0]) : longint'(s[63:0]);
   endfunction

   // one cell in, at most one flux item out
   task automatic predict_cell();
      longint   rho, u, p, e, a, m, mp, mm, pp, pm, g0, g1, g2, sqp, qm, mi;
      longint   f0, f1, f2;
      logic     upwind;
      flux_type f;
      clip = 1'b0;
      rho  = clampw(longint'(req_cell_density));
      u    = clampw(longint'(req_cell_velocity));
      p    = clampw(longint'(req_cell_pressure));
      e    = clampw(longint'(req_cell_energy));
      a    = clampw(longint'(req_cell_sound_speed));
      m    = divq(u, a);
      if (m >= -ONE_Q && m <= ONE_Q) begin
         sqp = mulq(m + ONE_Q, m + ONE_Q);
         qm  = mulq(m - ONE_Q, m - ONE_Q) >>> 2;
         mp  = sqp >>> 2;
         mm  = -qm;
         pp  = mulq(mulq(mp, clampw(2 * ONE_Q - m)), p);
         pm  = mulq(mulq(qm, clampw(2 * ONE_Q + m)), p);
      end else if (m > 0) begin
         mp = m; mm = 0; pp = p; pm = 0;
      end else begin
         mp = 0; mm = m; pp = 0; pm = p;
      end
      g0 = mulq(rho, a);
      g1 = mulq(g0, u);
      g2 = mulq(a, sat_add(e, p));
      if (!req_start_of_line && have_prev) begin
         mi     = sat_add(prev_mp, mm);
         upwind = mi >= 0;
         f0 = mulq(mi, upwind ? prev_g0 : g0);
         f1 = mulq(mi, upwind ? prev_g1 : g1);
         f2 = mulq(mi, upwind ? prev_g2 : g2);
         f1 = sat_add(f1, sat_add(prev_pp, pm));
         f.mass     = f0[31:0];
         f.momentum = f1[31:0];
         f.energy   = f2[31:0];
         f.sat      = clip;
         flux_q.push_back(f);
      end
      prev_mp   = mp;
      prev_pp   = pp;
      prev_g0   = g0;
      prev_g1   = g1;
      prev_g2   = g2;
      have_prev = 1'b1;
   endtask

   initial begin
      fail_count = 0;
      have_prev  = 1'b0;
      prev_mp = 0; prev_pp = 0; prev_g0 = 0; prev_g1 = 0; prev_g2 = 0;
   end

   assign pending = flux_q.size();

   // cells in, flux items out
   always @(posedge clock) begin
      flux_type f;
      if (reset) begin
         have_prev = 1'b0;
         prev_mp = 0; prev_pp = 0; prev_g0 = 0; prev_g1 = 0; prev_g2 = 0;
         flux_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (flux_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected flux item: %0d %0d %0d sat %0b", rsp_mass_flux,
                           rsp_momentum_flux, rsp_energy_flux, rsp_saturated);
            end else begin
               f = flux_q.pop_front();
               if (f.mass !== rsp_mass_flux || f.momentum !== rsp_momentum_flux ||
                   f.energy !== rsp_energy_flux || f.sat !== rsp_saturated) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("flux mismatch: exp %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                              f.mass, f.momentum, f.energy, f.sat, rsp_mass_flux,
                              rsp_momentum_flux, rsp_energy_flux, rsp_saturated);
               end
            end
         end
         if (req_valid && req_ready) predict_cell();
      end
   end

endmodule

// ===== tb/tb_ausm_interface_flux.sv =====
module tb_ausm_interface_flux;

   localparam int RANDOM_CELLS = 500;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 800;
   localparam int DRAIN_CYCLES = 200;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_start_of_line;
   logic [30:0]        req_cell_density;
   logic signed [31:0] req_cell_velocity;
   logic [30:0]        req_cell_pressure;
   logic [30:0]        req_cell_energy;
   logic [30:0]        req_cell_sound_speed;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_mass_flux;
   logic signed [31:0] rsp_momentum_flux;
   logic signed [31:0] rsp_energy_flux;
   logic               rsp_saturated;
   int                 fail_count;
   int                 pending;
   logic               hold_request;
   int                 cycle_count;

   ausm_interface_flux u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_of_line(req_start_of_line), .req_cell_density(req_cell_density),
      .req_cell_velocity(req_cell_velocity), .req_cell_pressure(req_cell_pressure),
      .req_cell_energy(req_cell_energy), .req_cell_sound_speed(req_cell_sound_speed),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mass_flux(rsp_mass_flux), .rsp_momentum_flux(rsp_momentum_flux),
      .rsp_energy_flux(rsp_energy_flux), .rsp_saturated(rsp_saturated)
   );

   ausm_flux_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_of_line(req_start_of_line), .req_cell_density(req_cell_density),
      .req_cell_velocity(req_cell_velocity), .req_cell_pressure(req_cell_pressure),
      .req_cell_energy(req_cell_energy), .req_cell_sound_speed(req_cell_sound_speed),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mass_flux(rsp_mass_flux), .rsp_momentum_flux(rsp_momentum_flux),
      .rsp_energy_flux(rsp_energy_flux), .rsp_saturated(rsp_saturated),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            g = gap_len();
            rsp_ready = (g == 0);
            repeat (g > 0 ? g : 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // offer one cell and wait until it is taken; called just after a falling edge
   task automatic send_cell(logic sol, logic [30:0] rho, logic signed [31:0] u,
                            logic [30:0] p, logic [30:0] e, logic [30:0] a);
      int g;
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid            = 1'b1;
      req_start_of_line    = sol;
      req_cell_density     = rho;
      req_cell_velocity    = u;
      req_cell_pressure    = p;
      req_cell_energy      = e;
      req_cell_sound_speed = a;
      forever begin
         #1;
         if (req_ready) begin
            @(negedge clock);
            break;
         end
         @(negedge clock);
      end
   endtask

   // a plausible cell: modest sound speed, Mach within +-3
   task automatic send_plausible(logic sol);
      logic [30:0]        a;
      logic signed [31:0] u;
      longint             uv;
      a  = 31'($urandom_range(1 << 12, 1 << 20));
      uv = (longint'(a) * (int'($urandom_range(0, 600)) - 300)) / 100;
      u  = uv[31:0];
      send_cell(sol, 31'($urandom_range(1, 1 << 22)), u, 31'($urandom_range(0, 1 << 22)),
                31'($urandom_range(0, 1 << 24)), a);
   endtask

   initial begin
      int r;
      hold_request         = 1'b0;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_start_of_line    = 1'b0;
      req_cell_density     = '0;
      req_cell_velocity    = '0;
      req_cell_pressure    = '0;
      req_cell_energy      = '0;
      req_cell_sound_speed = 31'd1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: first cell after reset, subsonic, sonic, supersonic, extremes
      send_cell(1'b0, 31'h10000, 32'sd0, 31'h10000, 31'h20000, 31'h10000);
      send_cell(1'b0, 31'h10000, 32'sh8000, 31'h10000, 31'h20000, 31'h10000);
      send_cell(1'b0, 31'h10000, 32'sh10000, 31'h10000, 31'h20000, 31'h10000);
      send_cell(1'b0, 31'h10000, -32'sh10000, 31'h10000, 31'h20000, 31'h10000);
      send_cell(1'b0, 31'h20000, 32'sh30000, 31'h8000, 31'h40000, 31'h10000);
      send_cell(1'b0, 31'h20000, -32'sh30000, 31'h8000, 31'h40000, 31'h10000);
      send_cell(1'b1, 31'h10000, -32'sh4000, 31'h10000, 31'h10000, 31'h18000);
      send_cell(1'b0, 31'd1, 32'sd0, 31'd0, 31'd0, 31'd1);
      send_cell(1'b0, 31'h7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1);
      send_cell(1'b0, 31'h7FFFFFFF, -32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1);
      send_cell(1'b0, 31'h7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                31'h7FFFFFFF);
      send_cell(1'b0, 31'd1, -32'sh80000000, 31'd0, 31'd0, 31'h7FFFFFFF);
      send_cell(1'b0, 31'h400000, 32'sh100000, 31'h400000, 31'h7FFFFFFF, 31'h100000);
      send_cell(1'b0, 31'h400000, -32'sh100000, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h100000);
      send_cell(1'b1, 31'h10000, 32'sh10000, 31'h10000, 31'h10000, 31'h10000);
      send_cell(1'b1, 31'h10000, 32'sh10000, 31'h10000, 31'h10000, 31'h10000);
      send_cell(1'b0, 31'h10000, 32'sh0, 31'h0, 31'h0, 31'h10000);

      // random: mostly plausible lines, some raw noise
      for (int i = 0; i < RANDOM_CELLS; i++) begin
         if (i == 100) hold_request = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 75)
            send_plausible($urandom_range(0, 11) == 0);
         else
            send_cell(1'($urandom_range(0, 1)), 31'($urandom_range(1, 31'h7FFFFFFF)),
                      $urandom, 31'($urandom), 31'($urandom),
                      31'($urandom_range(1, 31'h7FFFFFFF)));
      end
      req_valid = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
src/ausm_pkg.sv
src/ausm_ctrl.sv
src/ausm_dpath.sv
src/ausm_interface_flux.sv
tb/ausm_flux_checker.sv
tb/tb_ausm_interface_flux.sv
